@@ src/sitc_pkg.sv @@
// Shared types, constants and helpers for the sample index to timecode block.
// Depends on nothing; every other file imports it.
package sitc_pkg;

	localparam int RATE_BITS = 19;
	localparam int MODE_BITS = 2;
	localparam int HSEC_BITS = 12;
	localparam int HOUR_BITS = 8;
	localparam int MIN_BITS = 6;
	localparam int SEC_BITS = 6;
	localparam int PROD_BITS = 2 * RATE_BITS;
	localparam int FRAC_STEPS = RATE_BITS;

	localparam logic [RATE_BITS-1:0] RATE_RESET = 19'd48000;

	localparam logic [MODE_BITS-1:0] MODE_SAMPLES = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_MILLIS = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_FRAMES = 2'd2;

	localparam logic [RATE_BITS-1:0] UNIT_MILLIS = 19'd1000;
	localparam logic [RATE_BITS-1:0] UNIT_FRAMES = 19'd30;

	localparam logic [HSEC_BITS:0] SEC_PER_HOUR = 13'd3600;
	localparam logic [HSEC_BITS-1:0] SEC_PER_MIN = 12'd60;

	typedef struct packed {
		logic [RATE_BITS-1:0] rate;
		logic [RATE_BITS-1:0] unit;
	} cfg_t;

	typedef struct packed {
		logic                 valid;
		logic                 neg;
		logic [RATE_BITS-1:0] rem;
		logic [HSEC_BITS-1:0] hsec;
		logic [HOUR_BITS-1:0] hours;
	} sec_out_t;

	typedef struct packed {
		logic                 valid;
		logic                 neg;
		logic [HOUR_BITS-1:0] hours;
		logic [MIN_BITS-1:0]  minutes;
		logic [SEC_BITS-1:0]  seconds;
		logic [RATE_BITS-1:0] fraction;
	} frac_out_t;

	function automatic logic [RATE_BITS-1:0] unit_for_mode(
		input logic [MODE_BITS-1:0] mode,
		input logic [RATE_BITS-1:0] rate
	);
		logic [RATE_BITS-1:0] unit;
		case (mode)
			MODE_MILLIS: unit = UNIT_MILLIS;
			MODE_FRAMES: unit = UNIT_FRAMES;
			default:     unit = rate;
		endcase
		return unit;
	endfunction

endpackage

@@ src/sitc_regs.sv @@
// Configuration registers behind the APB-style port: sample rate and fraction mode.
// Depends on sitc_pkg.
module sitc_regs
	import sitc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	localparam logic REG_RATE = 1'b0;
	localparam logic REG_FRACTION_MODE = 1'b1;

	logic [RATE_BITS-1:0] rate_q;
	logic [MODE_BITS-1:0] mode_q;
	logic                 wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
			mode_q <= MODE_SAMPLES;
		end else if (wr_en) begin
			case (paddr[2])
				REG_RATE:          rate_q <= pwdata[RATE_BITS-1:0];
				REG_FRACTION_MODE: mode_q <= pwdata[MODE_BITS-1:0];
				default:           rate_q <= rate_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_RATE:          prdata = {{(32-RATE_BITS){1'b0}}, rate_q};
			REG_FRACTION_MODE: prdata = {{(32-MODE_BITS){1'b0}}, mode_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg.rate = rate_q;
	assign cfg.unit = unit_for_mode(mode_q, rate_q);

endmodule

@@ src/sitc_sec_div.sv @@
// Magnitude and whole-second pipeline: one quotient bit per stage, with the
// hour split riding on each new quotient bit. Depends on sitc_pkg.
module sitc_sec_div
	import sitc_pkg::*;
#(
	parameter int POSITION_BITS = 41
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic signed [POSITION_BITS-1:0] position,
	input  logic [RATE_BITS-1:0]            rate,
	output sec_out_t                        result
);

	logic [POSITION_BITS-1:0] pos_u;
	logic [POSITION_BITS-1:0] mag_s  [0:POSITION_BITS-1];
	logic [RATE_BITS-1:0]     rem_s  [0:POSITION_BITS];
	logic [HSEC_BITS-1:0]     hsec_s [0:POSITION_BITS];
	logic [HOUR_BITS-1:0]     hour_s [0:POSITION_BITS];
	logic                     neg_s  [0:POSITION_BITS];
	logic                     vld_s  [0:POSITION_BITS];

	assign pos_u = position;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		mag_s[0]  <= pos_u[POSITION_BITS-1] ? (~pos_u + 1'b1) : pos_u;
		neg_s[0]  <= pos_u[POSITION_BITS-1];
		rem_s[0]  <= '0;
		hsec_s[0] <= '0;
		hour_s[0] <= '0;
	end

	for (genvar k = 0; k < POSITION_BITS; k++) begin : g_stage
		logic [RATE_BITS:0]   part;
		logic [RATE_BITS:0]   diff;
		logic                 ge;
		logic [HSEC_BITS:0]   hpart;
		logic [HSEC_BITS:0]   hdiff;
		logic                 hge;

		always_comb begin
			part  = {rem_s[k], mag_s[k][POSITION_BITS-1-k]};
			diff  = part - {1'b0, rate};
			ge    = part >= {1'b0, rate};
			hpart = {hsec_s[k], ge};
			hdiff = hpart - SEC_PER_HOUR;
			hge   = hpart >= SEC_PER_HOUR;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? diff[RATE_BITS-1:0] : part[RATE_BITS-1:0];
			hsec_s[k+1] <= hge ? hdiff[HSEC_BITS-1:0] : hpart[HSEC_BITS-1:0];
			hour_s[k+1] <= {hour_s[k][HOUR_BITS-2:0], hge};
			neg_s[k+1]  <= neg_s[k];
		end

		if (k < POSITION_BITS - 1) begin : g_mag
			always_ff @(posedge clk) begin
				mag_s[k+1] <= mag_s[k];
			end
		end
	end

	assign result.valid = vld_s[POSITION_BITS];
	assign result.neg   = neg_s[POSITION_BITS];
	assign result.rem   = rem_s[POSITION_BITS];
	assign result.hsec  = hsec_s[POSITION_BITS];
	assign result.hours = hour_s[POSITION_BITS];

endmodule

@@ src/sitc_frac_div.sv @@
// Fraction pipeline: scales the in-second remainder by the unit and divides by
// the rate one bit per stage, and splits minutes and seconds. Depends on sitc_pkg.
module sitc_frac_div
	import sitc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  sec_out_t             sec_in,
	input  logic [RATE_BITS-1:0] rate,
	input  logic [RATE_BITS-1:0] unit,
	output frac_out_t            result
);

	logic [HSEC_BITS-1:0] ms_rem;
	logic [MIN_BITS-1:0]  ms_q;

	logic [RATE_BITS-1:0] frem_s  [0:FRAC_STEPS];
	logic [RATE_BITS-1:0] fbits_s [0:FRAC_STEPS-1];
	logic [RATE_BITS-1:0] fq_s    [0:FRAC_STEPS];
	logic [HOUR_BITS-1:0] hour_s  [0:FRAC_STEPS];
	logic [MIN_BITS-1:0]  min_s   [0:FRAC_STEPS];
	logic [SEC_BITS-1:0]  sec_s   [0:FRAC_STEPS];
	logic                 neg_s   [0:FRAC_STEPS];
	logic                 vld_s   [0:FRAC_STEPS];
	logic [PROD_BITS-1:0] prod;

	always_comb begin
		ms_rem = sec_in.hsec;
		ms_q   = '0;
		for (int i = MIN_BITS - 1; i >= 0; i--) begin
			if (ms_rem >= (SEC_PER_MIN << i)) begin
				ms_rem  = ms_rem - (SEC_PER_MIN << i);
				ms_q[i] = 1'b1;
			end
		end
	end

	assign prod = PROD_BITS'(sec_in.rem) * PROD_BITS'(unit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= sec_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		frem_s[0]  <= prod[PROD_BITS-1:FRAC_STEPS];
		fbits_s[0] <= prod[FRAC_STEPS-1:0];
		fq_s[0]    <= '0;
		hour_s[0]  <= sec_in.hours;
		min_s[0]   <= ms_q;
		sec_s[0]   <= ms_rem[SEC_BITS-1:0];
		neg_s[0]   <= sec_in.neg;
	end

	for (genvar k = 0; k < FRAC_STEPS; k++) begin : g_stage
		logic [RATE_BITS:0] part;
		logic [RATE_BITS:0] diff;
		logic               ge;

		always_comb begin
			part = {frem_s[k], fbits_s[k][FRAC_STEPS-1-k]};
			diff = part - {1'b0, rate};
			ge   = part >= {1'b0, rate};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			frem_s[k+1] <= ge ? diff[RATE_BITS-1:0] : part[RATE_BITS-1:0];
			fq_s[k+1]   <= {fq_s[k][RATE_BITS-2:0], ge};
			hour_s[k+1] <= hour_s[k];
			min_s[k+1]  <= min_s[k];
			sec_s[k+1]  <= sec_s[k];
			neg_s[k+1]  <= neg_s[k];
		end

		if (k < FRAC_STEPS - 1) begin : g_bits
			always_ff @(posedge clk) begin
				fbits_s[k+1] <= fbits_s[k];
			end
		end
	end

	assign result.valid    = vld_s[FRAC_STEPS];
	assign result.neg      = neg_s[FRAC_STEPS];
	assign result.hours    = hour_s[FRAC_STEPS];
	assign result.minutes  = min_s[FRAC_STEPS];
	assign result.seconds  = sec_s[FRAC_STEPS];
	assign result.fraction = fq_s[FRAC_STEPS];

endmodule

@@ src/sample_index_to_timecode.sv @@
// Top level of the sample index to timecode converter.
// Depends on sitc_pkg, sitc_regs, sitc_sec_div and sitc_frac_div.
//
// A transaction is accepted at each rising edge with start high; busy is
// always low, so one position can be taken in every cycle.
// The result reaches the output ports through the stages listed below and
// stays for one cycle, marked by done. The path holds one magnitude register
// loaded at the accepting edge itself, one restoring-division stage per
// position bit for the whole seconds (the hour split rides along on each
// quotient bit), a multiply stage that also splits minutes and seconds,
// nineteen division stages for the fraction and the output register.
// Throughput is one result per cycle. The receiver cannot stall, so the
// pipeline never holds.
// Reset clears the valid bits of every stage and loads a sample rate of 48000
// and the sample fraction mode. Registers sit at byte 0 (sample rate) and
// byte 4 (fraction mode) and must only be written while no transaction is in
// flight. A sample rate of zero yields zero time fields.
module sample_index_to_timecode
	import sitc_pkg::*;
#(
	parameter int POSITION_BITS = 41
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [POSITION_BITS-1:0] position,
	output logic                            done,
	output logic                            is_negative,
	output logic [HOUR_BITS-1:0]            hours,
	output logic [MIN_BITS-1:0]             minutes,
	output logic [SEC_BITS-1:0]             seconds,
	output logic [RATE_BITS-1:0]            fraction,
	output logic [RATE_BITS-1:0]            frac_scale,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	cfg_t      cfg;
	sec_out_t  sec_res;
	frac_out_t frac_res;
	logic      rate_zero;

	assign busy = 1'b0;

	sitc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sitc_sec_div #(
		.POSITION_BITS (POSITION_BITS)
	) u_sec_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.position (position),
		.rate     (cfg.rate),
		.result   (sec_res)
	);

	sitc_frac_div u_frac_div (
		.clk    (clk),
		.arst_n (arst_n),
		.sec_in (sec_res),
		.rate   (cfg.rate),
		.unit   (cfg.unit),
		.result (frac_res)
	);

	assign rate_zero = (cfg.rate == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= frac_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		is_negative <= frac_res.neg;
		hours       <= rate_zero ? '0 : frac_res.hours;
		minutes     <= rate_zero ? '0 : frac_res.minutes;
		seconds     <= rate_zero ? '0 : frac_res.seconds;
		fraction    <= rate_zero ? '0 : frac_res.fraction;
		frac_scale  <= cfg.unit;
	end

endmodule
